/* src/round_robin_task_scheduler_defines.svh */
// Assertion macros for the round-robin task scheduler.
// Included by the top level; needs nothing else.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define RRTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define RRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

/* src/rrts_pkg.sv */
// Shared types and constants of the round-robin task scheduler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

  localparam int unsigned TID_W      = 32;
  localparam int unsigned TICK_W     = 32;
  localparam int unsigned SLICE_W    = 16;
  localparam int unsigned OUT_SLOT_W = 4;
  localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd10;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_TICK     = 2'd1,
    OP_SLEEP    = 2'd2,
    OP_EXIT     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PICK_HEAD = 2'd0,
    PICK_NEXT = 2'd1,
    PICK_SUCC = 2'd2
  } pick_mode_t;

  // Controls of one run-ring cell.
  typedef struct packed {
    logic load;
    logic shift;
  } ring_ctrl_t;

  // Controls of one wait-list cell.
  typedef struct packed {
    logic load;
    logic shift;
    logic age;
  } wait_ctrl_t;

endpackage

`default_nettype wire

/* src/rrts_ring_cell.sv */
// One run-ring cell: holds a slot number and its task id.
// Depends on rrts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrts_ring_cell
  import rrts_pkg::*;
#(
  parameter int unsigned SLOT_W = 4
) (
  input  wire logic              clk,
  input  wire ring_ctrl_t        ctrl,
  input  wire logic [SLOT_W-1:0] ld_slot,
  input  wire logic [TID_W-1:0]  ld_tid,
  input  wire logic [SLOT_W-1:0] nb_slot,
  input  wire logic [TID_W-1:0]  nb_tid,
  output logic      [SLOT_W-1:0] slot,
  output logic      [TID_W-1:0]  tid
);

  logic [SLOT_W-1:0] slot_r;
  logic [TID_W-1:0]  tid_r;

  // Load wins over a shift from the neighbor.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      slot_r <= ld_slot;
      tid_r  <= ld_tid;
    end else if (ctrl.shift) begin
      slot_r <= nb_slot;
      tid_r  <= nb_tid;
    end
  end

  assign slot = slot_r;
  assign tid  = tid_r;

endmodule

`default_nettype wire

/* src/rrts_wait_cell.sv */
// One wait-list cell: slot, task id, elapsed ticks and sleep length.
// Depends on rrts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrts_wait_cell
  import rrts_pkg::*;
#(
  parameter int unsigned SLOT_W = 4
) (
  input  wire logic              clk,
  input  wire wait_ctrl_t        ctrl,
  input  wire logic [SLOT_W-1:0] ld_slot,
  input  wire logic [TID_W-1:0]  ld_tid,
  input  wire logic [TICK_W-1:0] ld_elapsed,
  input  wire logic [TICK_W-1:0] ld_length,
  input  wire logic [SLOT_W-1:0] nb_slot,
  input  wire logic [TID_W-1:0]  nb_tid,
  input  wire logic [TICK_W-1:0] nb_elapsed,
  input  wire logic [TICK_W-1:0] nb_length,
  output logic      [SLOT_W-1:0] slot,
  output logic      [TID_W-1:0]  tid,
  output logic      [TICK_W-1:0] elapsed,
  output logic      [TICK_W-1:0] length
);

  logic [SLOT_W-1:0] slot_r;
  logic [TID_W-1:0]  tid_r;
  logic [TICK_W-1:0] elapsed_r;
  logic [TICK_W-1:0] length_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      slot_r    <= ld_slot;
      tid_r     <= ld_tid;
      elapsed_r <= ld_elapsed;
      length_r  <= ld_length;
    end else if (ctrl.shift) begin
      slot_r    <= nb_slot;
      tid_r     <= nb_tid;
      elapsed_r <= nb_elapsed;
      length_r  <= nb_length;
    end else if (ctrl.age && (elapsed_r != '1)) begin
      // saturate at all ones
      elapsed_r <= elapsed_r + TICK_W'(1);
    end
  end

  assign slot    = slot_r;
  assign tid     = tid_r;
  assign elapsed = elapsed_r;
  assign length  = length_r;

endmodule

`default_nettype wire

/* src/round_robin_task_scheduler.sv */
// Round-robin task scheduler over MAX_TASKS slots with a sleep queue.
// Depends on rrts_pkg, rrts_ring_cell, rrts_wait_cell and the defines header.
//
// Each accepted event transaction (register, tick, sleep, exit) yields exactly one
// result transaction. The run ring and the wait list are rows of cells that hand
// entries to their neighbor; a task id travels with its slot through the rows.
// Steps: a register event runs a free-slot scan that checks one slot a cycle. A
// tick that keeps the running task goes straight to the finish state. An event
// that reschedules runs a wake pass that pops one sleeper a cycle off the
// wait-list head, then picks and selects the next task. One event is in flight
// at a time; the finished result sits in an output
// register so the next event is taken while it waits. No clearing pass after
// reset. The slice register is written through cfg_data and is always ready.
`timescale 1ns / 1ps
`default_nettype none

`include "round_robin_task_scheduler_defines.svh"

module round_robin_task_scheduler
  import rrts_pkg::*;
#(
  parameter int unsigned MAX_TASKS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_op,
  input  wire logic [TICK_W-1:0]     in_sleep_ticks,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [OUT_SLOT_W-1:0]      out_running_slot,
  output logic [TID_W-1:0]           out_running_tid,
  output logic                       out_idle_running,
  output logic                       out_register_ok,
  output logic [TID_W-1:0]           out_new_tid,
  output logic                       out_switched,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [SLICE_W-1:0]    cfg_data
);

  localparam int unsigned IW = $clog2(MAX_TASKS);
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);
  localparam int unsigned PW = (IW > OUT_SLOT_W) ? IW : OUT_SLOT_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_REG  = 6'b000010,
    S_WAKE = 6'b000100,
    S_PICK = 6'b001000,
    S_SEL  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [MAX_TASKS-1:0] free_r, free_nxt;
  logic [CW-1:0]       rcount_r, rcount_nxt;
  logic [CW-1:0]       wcount_r, wcount_nxt;
  logic [CW-1:0]       wk_left_r, wk_left_nxt;
  logic [IW-1:0]       cur_r, cur_nxt;
  logic [IW-1:0]       succ_r, succ_nxt;
  logic [IW-1:0]       scan_r, scan_nxt;
  logic                idle_r, idle_nxt;
  logic [TID_W-1:0]    next_tid_r, next_tid_nxt;
  logic [TICK_W-1:0]   run_el_r, run_el_nxt;
  logic [IW-1:0]       run_slot_r, run_slot_nxt;
  logic [TID_W-1:0]    run_tid_r, run_tid_nxt;
  pick_mode_t          mode_r, mode_nxt;
  logic                switched_r, switched_nxt;
  logic                reg_ok_r, reg_ok_nxt;
  logic [TID_W-1:0]    new_tid_r, new_tid_nxt;
  logic [SLICE_W-1:0]  slice_r;

  logic                out_valid_r, out_valid_nxt;
  logic [OUT_SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [TID_W-1:0]    out_tid_r, out_tid_nxt;
  logic                out_idle_r, out_idle_nxt;
  logic                out_ok_r, out_ok_nxt;
  logic [TID_W-1:0]    out_new_r, out_new_nxt;
  logic                out_sw_r, out_sw_nxt;

  // Cell rows
  ring_ctrl_t          r_ctrl [MAX_TASKS];
  wait_ctrl_t          w_ctrl [MAX_TASKS];
  logic [IW-1:0]       r_slot [MAX_TASKS];
  logic [TID_W-1:0]    r_tid  [MAX_TASKS];
  logic [IW-1:0]       w_slot [MAX_TASKS];
  logic [TID_W-1:0]    w_tid  [MAX_TASKS];
  logic [TICK_W-1:0]   w_el   [MAX_TASKS];
  logic [TICK_W-1:0]   w_len  [MAX_TASKS];

  logic [IW-1:0]       r_ld_slot;
  logic [TID_W-1:0]    r_ld_tid;
  logic [IW-1:0]       w_ld_slot;
  logic [TID_W-1:0]    w_ld_tid;
  logic [TICK_W-1:0]   w_ld_el;
  logic [TICK_W-1:0]   w_ld_len;

  logic                ring_app, ring_rm, wait_ld, wait_shift, wait_age;
  logic [CW-1:0]       wait_ld_idx;
  logic [IW-1:0]       sel_slot;
  logic [TID_W-1:0]    sel_tid;
  logic [TICK_W-1:0]   run_inc;
  logic [PW-1:0]       slot_pad;
  logic                accept;

  genvar g;
  generate
    for (g = 0; g < MAX_TASKS; g++) begin : g_cells
      logic [IW-1:0]     rn_slot, wn_slot;
      logic [TID_W-1:0]  rn_tid, wn_tid;
      logic [TICK_W-1:0] wn_el, wn_len;

      // The last cell takes in nothing from beyond the row.
      if (g == MAX_TASKS - 1) begin : g_last
        assign rn_slot = '0;
        assign rn_tid  = '0;
        assign wn_slot = '0;
        assign wn_tid  = '0;
        assign wn_el   = '0;
        assign wn_len  = '0;
      end else begin : g_mid
        assign rn_slot = r_slot[g+1];
        assign rn_tid  = r_tid[g+1];
        assign wn_slot = w_slot[g+1];
        assign wn_tid  = w_tid[g+1];
        assign wn_el   = w_el[g+1];
        assign wn_len  = w_len[g+1];
      end

      rrts_ring_cell #(.SLOT_W(IW)) u_ring (
        .clk     (clk),
        .ctrl    (r_ctrl[g]),
        .ld_slot (r_ld_slot),
        .ld_tid  (r_ld_tid),
        .nb_slot (rn_slot),
        .nb_tid  (rn_tid),
        .slot    (r_slot[g]),
        .tid     (r_tid[g])
      );

      rrts_wait_cell #(.SLOT_W(IW)) u_wait (
        .clk        (clk),
        .ctrl       (w_ctrl[g]),
        .ld_slot    (w_ld_slot),
        .ld_tid     (w_ld_tid),
        .ld_elapsed (w_ld_el),
        .ld_length  (w_ld_len),
        .nb_slot    (wn_slot),
        .nb_tid     (wn_tid),
        .nb_elapsed (wn_el),
        .nb_length  (wn_len),
        .slot       (w_slot[g]),
        .tid        (w_tid[g]),
        .elapsed    (w_el[g]),
        .length     (w_len[g])
      );
    end
  endgenerate

  // Pick out the ring entry at the current position with an AND-OR select over the cells.
  always_comb begin
    sel_slot = '0;
    sel_tid  = '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (IW'(i) == cur_r) begin
        sel_slot = sel_slot | r_slot[i];
        sel_tid  = sel_tid | r_tid[i];
      end
    end
  end

  assign accept    = in_valid && (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign run_inc   = (run_el_r == '1) ? run_el_r : run_el_r + TICK_W'(1);
  assign slot_pad  = PW'(run_slot_r);

  always_comb begin
    state_nxt    = state_r;
    free_nxt     = free_r;
    rcount_nxt   = rcount_r;
    wcount_nxt   = wcount_r;
    wk_left_nxt  = wk_left_r;
    cur_nxt      = cur_r;
    succ_nxt     = succ_r;
    scan_nxt     = scan_r;
    idle_nxt     = idle_r;
    next_tid_nxt = next_tid_r;
    run_el_nxt   = run_el_r;
    run_slot_nxt = run_slot_r;
    run_tid_nxt  = run_tid_r;
    mode_nxt     = mode_r;
    switched_nxt = switched_r;
    reg_ok_nxt   = reg_ok_r;
    new_tid_nxt  = new_tid_r;

    out_valid_nxt = out_valid_r && out_stall;
    out_slot_nxt  = out_slot_r;
    out_tid_nxt   = out_tid_r;
    out_idle_nxt  = out_idle_r;
    out_ok_nxt    = out_ok_r;
    out_new_nxt   = out_new_r;
    out_sw_nxt    = out_sw_r;

    ring_app    = 1'b0;
    ring_rm     = 1'b0;
    wait_ld     = 1'b0;
    wait_shift  = 1'b0;
    wait_age    = 1'b0;
    wait_ld_idx = wcount_r;
    r_ld_slot   = w_slot[0];
    r_ld_tid    = w_tid[0];
    w_ld_slot   = w_slot[0];
    w_ld_tid    = w_tid[0];
    w_ld_el     = w_el[0];
    w_ld_len    = w_len[0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          reg_ok_nxt   = 1'b0;
          new_tid_nxt  = '0;
          switched_nxt = 1'b0;
          unique case (op_t'(in_op))
            OP_REGISTER: begin
              scan_nxt  = '0;
              state_nxt = S_REG;
            end
            OP_TICK: begin
              // age every sleeper, then the running slice
              wait_age    = 1'b1;
              wk_left_nxt = wcount_r;
              if (idle_r) begin
                mode_nxt     = PICK_HEAD;
                switched_nxt = 1'b1;
                state_nxt    = S_WAKE;
              end else if (run_inc >= TICK_W'(slice_r)) begin
                run_el_nxt   = '0;
                mode_nxt     = PICK_NEXT;
                switched_nxt = 1'b1;
                state_nxt    = S_WAKE;
              end else begin
                run_el_nxt = run_inc;
                state_nxt  = S_FIN;
              end
            end
            OP_SLEEP, OP_EXIT: begin
              if (idle_r) begin
                state_nxt = S_FIN;
              end else begin
                // drop the running task from the ring
                ring_rm    = 1'b1;
                rcount_nxt = rcount_r - CW'(1);
                if (op_t'(in_op) == OP_SLEEP) begin
                  wait_ld     = 1'b1;
                  wait_ld_idx = wcount_r;
                  w_ld_slot   = run_slot_r;
                  w_ld_tid    = run_tid_r;
                  w_ld_el     = '0;
                  w_ld_len    = in_sleep_ticks;
                  wcount_nxt  = wcount_r + CW'(1);
                  wk_left_nxt = wcount_r + CW'(1);
                end else begin
                  free_nxt[run_slot_r] = 1'b1;
                  wk_left_nxt          = wcount_r;
                end
                succ_nxt     = cur_r;
                mode_nxt     = PICK_SUCC;
                switched_nxt = 1'b1;
                state_nxt    = S_WAKE;
              end
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end

      S_REG: begin
        if (free_r[scan_r]) begin
          free_nxt[scan_r] = 1'b0;
          ring_app         = 1'b1;
          r_ld_slot        = scan_r;
          r_ld_tid         = next_tid_r;
          rcount_nxt       = rcount_r + CW'(1);
          reg_ok_nxt       = 1'b1;
          new_tid_nxt      = next_tid_r;
          next_tid_nxt     = next_tid_r + TID_W'(1);
          state_nxt        = S_FIN;
        end else if (scan_r == IW'(MAX_TASKS - 1)) begin
          state_nxt = S_FIN;
        end else begin
          scan_nxt = scan_r + IW'(1);
        end
      end

      S_WAKE: begin
        if (wk_left_r == '0) begin
          state_nxt = S_PICK;
        end else begin
          // pop the head; due sleepers go to the ring tail, the rest rotate back
          wait_shift  = 1'b1;
          wk_left_nxt = wk_left_r - CW'(1);
          if (w_el[0] >= w_len[0]) begin
            ring_app   = 1'b1;
            rcount_nxt = rcount_r + CW'(1);
            wcount_nxt = wcount_r - CW'(1);
          end else begin
            wait_ld     = 1'b1;
            wait_ld_idx = wcount_r - CW'(1);
          end
        end
      end

      S_PICK: begin
        if (rcount_r == '0) begin
          idle_nxt  = 1'b1;
          cur_nxt   = '0;
          state_nxt = S_FIN;
        end else begin
          unique case (mode_r)
            PICK_NEXT: cur_nxt = ((CW'(cur_r) + CW'(1)) >= rcount_r) ? '0 : cur_r + IW'(1);
            PICK_SUCC: cur_nxt = (CW'(succ_r) < rcount_r) ? succ_r : '0;
            default:   cur_nxt = '0;
          endcase
          idle_nxt   = 1'b0;
          run_el_nxt = '0;
          state_nxt  = S_SEL;
        end
      end

      S_SEL: begin
        run_slot_nxt = sel_slot;
        run_tid_nxt  = sel_tid;
        state_nxt    = S_FIN;
      end

      S_FIN: begin
        // hold the result until the output register frees up
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt  = idle_r ? '0 : slot_pad[OUT_SLOT_W-1:0];
          out_tid_nxt   = idle_r ? '0 : run_tid_r;
          out_idle_nxt  = idle_r;
          out_ok_nxt    = reg_ok_r;
          out_new_nxt   = new_tid_r;
          out_sw_nxt    = switched_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    for (int i = 0; i < MAX_TASKS; i++) begin
      r_ctrl[i].load  = ring_app && (CW'(i) == rcount_r);
      r_ctrl[i].shift = ring_rm && (IW'(i) >= cur_r);
      w_ctrl[i].load  = wait_ld && (CW'(i) == wait_ld_idx);
      w_ctrl[i].shift = wait_shift;
      w_ctrl[i].age   = wait_age;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_r      <= '1;
      rcount_r    <= '0;
      wcount_r    <= '0;
      wk_left_r   <= '0;
      cur_r       <= '0;
      idle_r      <= 1'b1;
      next_tid_r  <= '0;
      run_el_r    <= '0;
      slice_r     <= SLICE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_r      <= free_nxt;
      rcount_r    <= rcount_nxt;
      wcount_r    <= wcount_nxt;
      wk_left_r   <= wk_left_nxt;
      cur_r       <= cur_nxt;
      idle_r      <= idle_nxt;
      next_tid_r  <= next_tid_nxt;
      run_el_r    <= run_el_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        slice_r <= cfg_data;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    succ_r     <= succ_nxt;
    scan_r     <= scan_nxt;
    run_slot_r <= run_slot_nxt;
    run_tid_r  <= run_tid_nxt;
    mode_r     <= mode_nxt;
    switched_r <= switched_nxt;
    reg_ok_r   <= reg_ok_nxt;
    new_tid_r  <= new_tid_nxt;
    out_slot_r <= out_slot_nxt;
    out_tid_r  <= out_tid_nxt;
    out_idle_r <= out_idle_nxt;
    out_ok_r   <= out_ok_nxt;
    out_new_r  <= out_new_nxt;
    out_sw_r   <= out_sw_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_running_slot = out_slot_r;
  assign out_running_tid  = out_tid_r;
  assign out_idle_running = out_idle_r;
  assign out_register_ok  = out_ok_r;
  assign out_new_tid      = out_new_r;
  assign out_switched     = out_sw_r;

  // Every slot is free, in the ring or in the wait list, between events.
  `RRTS_ASSERT_NOW(a_slot_accounting, clk, rst_n, state_r == S_IDLE,
    (CW + 1)'($countones(free_r)) + (CW + 1)'(rcount_r) + (CW + 1)'(wcount_r)
      == (CW + 1)'(MAX_TASKS))
  // A running task sits inside the ring.
  `RRTS_ASSERT_NOW(a_cur_in_ring, clk, rst_n, (state_r == S_IDLE) && !idle_r,
    CW'(cur_r) < rcount_r)
  // An accepted event always keeps the block busy in the next cycle.
  `RRTS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall,
    state_r != S_IDLE)
  // The wake pass never walks past the wait list.
  `RRTS_ASSERT_NOW(a_wake_bound, clk, rst_n, state_r == S_WAKE, wk_left_r <= wcount_r)

endmodule

`default_nettype wire
